// ===== rtl/core/tlex_pkg.sv =====
// Package for the token lexer: kind codes, keyword and operator tables,
// and the sequencer state type. No dependencies.
package tlex_pkg;

  localparam int KIND_W   = 6;
  localparam int NUM_KW   = 10;
  localparam int KW_MAXLEN = 6;

  localparam logic [KIND_W-1:0] KIND_IDENT = 6'd0;
  localparam logic [KIND_W-1:0] KIND_INT   = 6'd1;
  localparam logic [KIND_W-1:0] KIND_FLOAT = 6'd2;
  localparam logic [KIND_W-1:0] KIND_CHARC = 6'd3;
  localparam logic [KIND_W-1:0] KIND_KW0   = 6'd4;
  localparam logic [KIND_W-1:0] KIND_OP0   = 6'd14;

  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_ONE,
    ST_READ,
    ST_WORD,
    ST_OP
  } state_t;

  function automatic logic [8*KW_MAXLEN-1:0] kw_text(input logic [3:0] k);
    logic [8*KW_MAXLEN-1:0] t;
    unique case (k)
      4'd0:    t = "return";
      4'd1:    t = {"if", 32'h0};
      4'd2:    t = {"else", 16'h0};
      4'd3:    t = "struct";
      4'd4:    t = {"enum", 16'h0};
      4'd5:    t = {"union", 8'h0};
      4'd6:    t = {"mut", 24'h0};
      4'd7:    t = {"int", 24'h0};
      4'd8:    t = {"float", 8'h0};
      4'd9:    t = {"char", 16'h0};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [5:0] kw_len(input logic [3:0] k);
    logic [5:0] n;
    unique case (k)
      4'd0, 4'd3:       n = 6'd6;
      4'd1:             n = 6'd2;
      4'd2, 4'd4, 4'd9: n = 6'd4;
      4'd5, 4'd8:       n = 6'd5;
      4'd6, 4'd7:       n = 6'd3;
      default:          n = 6'd0;
    endcase
    return n;
  endfunction

  // True when byte b matches keyword k at position pos.
  function automatic logic kw_byte_ok(input logic [3:0] k, input logic [5:0] pos,
                                      input logic [7:0] b);
    logic [8*KW_MAXLEN-1:0] t;
    logic [2:0] p;
    t = kw_text(k);
    p = pos[2:0];
    if (pos >= kw_len(k)) begin
      return 1'b0;
    end
    return t[8*(KW_MAXLEN-1-int'(p)) +: 8] == b;
  endfunction

  // Bit 5 flags an operator byte, bits 4:0 give its index.
  function automatic logic [5:0] op_lookup(input logic [7:0] b);
    logic [5:0] r;
    unique case (b)
      8'h2b:   r = {1'b1, 5'd0};
      8'h2d:   r = {1'b1, 5'd1};
      8'h2a:   r = {1'b1, 5'd2};
      8'h2f:   r = {1'b1, 5'd3};
      8'h2c:   r = {1'b1, 5'd4};
      8'h2e:   r = {1'b1, 5'd5};
      8'h26:   r = {1'b1, 5'd6};
      8'h7c:   r = {1'b1, 5'd7};
      8'h5e:   r = {1'b1, 5'd8};
      8'h3d:   r = {1'b1, 5'd9};
      8'h21:   r = {1'b1, 5'd10};
      8'h7e:   r = {1'b1, 5'd11};
      8'h3c:   r = {1'b1, 5'd12};
      8'h3e:   r = {1'b1, 5'd13};
      8'h28:   r = {1'b1, 5'd14};
      8'h29:   r = {1'b1, 5'd15};
      8'h5b:   r = {1'b1, 5'd16};
      8'h5d:   r = {1'b1, 5'd17};
      8'h7b:   r = {1'b1, 5'd18};
      8'h7d:   r = {1'b1, 5'd19};
      8'h3b:   r = {1'b1, 5'd20};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

// ===== rtl/core/tlex_in_if.sv =====
// Input channel of the token lexer: one source byte per transfer.
// Depends on nothing.
interface tlex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

// ===== rtl/core/tlex_out_if.sv =====
// Output channel of the token lexer: one token result per transfer.
// Depends on nothing.
interface tlex_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] kind;
  logic [7:0] value_byte;
  logic       token_end;
  logic       truncated;
  logic       run_last;

  modport source (output valid, output kind, output value_byte, output token_end,
                  output truncated, output run_last, input ready);
  modport sink   (input valid, input kind, input value_byte, input token_end,
                  input truncated, input run_last, output ready);
endinterface

// ===== rtl/core/token_lexer.sv =====
// Token lexer top level: word store memory, classification trackers and
// result sequencer. Depends on tlex_pkg, tlex_in_if and tlex_out_if.
//
// Source bytes arrive on char_in, one per transfer; results leave on tok_out,
// one per transfer. An accepted word byte is written to the word store, or
// sets the overflow flag once the store is full; the block stays ready unless
// the byte ends the text. A byte that ends a word (blank, operator or end of
// text) starts a flush: a classify state, then one result per stored byte for
// identifiers and numbers, each by a read of the word store memory and a load
// of the output register, or a single result for keywords and character
// constants, followed by the operator result if any. An operator with no word
// pending yields its operator result alone. No new byte is taken while results
// of the previous one are still being produced, but a finished result may wait
// in the output register while the next byte is accepted. When tok_out.ready
// is low the output register holds its result and the sequencer waits. Reset
// (rst, synchronous) empties the word and the output register; the word store
// needs no clearing.
module token_lexer #(
  parameter int MAX_WORD = 32
) (
  input  logic       clk,
  input  logic       rst,
  tlex_in_if.sink    char_in,
  tlex_out_if.source tok_out
);

  localparam int LW = $clog2(MAX_WORD + 1);
  localparam int AW = $clog2(MAX_WORD);

  tlex_pkg::state_t state, state_next;

  logic [7:0]    word_store [MAX_WORD];
  logic [7:0]    rd_data;
  logic [LW-1:0] length;
  logic          overflow;
  logic [AW-1:0] idx;

  logic [tlex_pkg::NUM_KW-1:0] kw_match;
  logic [tlex_pkg::NUM_KW-1:0] kw_match_next;
  logic          quote_first;
  logic [7:0]    char_val;
  logic          nondig_seen;
  logic          nondig_dot;
  logic          op_pend;
  logic [tlex_pkg::KIND_W-1:0] op_kind;

  logic          out_valid;
  logic [tlex_pkg::KIND_W-1:0] out_kind;
  logic [7:0]    out_value;
  logic          out_end;
  logic          out_trunc;
  logic          out_last;

  logic          accept;
  logic [7:0]    b;
  logic [5:0]    op_info;
  logic          op_hit;
  logic          blank;
  logic          is_word;
  logic          store_ok;
  logic          need_flush;
  logic          first;
  logic          out_free;
  logic [tlex_pkg::KIND_W-1:0] word_kind;
  logic          word_multi;
  logic          last_byte;

  // Sequencer controls.
  logic          ld_out;
  logic [tlex_pkg::KIND_W-1:0] ld_kind;
  logic [7:0]    ld_value;
  logic          ld_end;
  logic          ld_trunc;
  logic          ld_last;
  logic          word_clear;
  logic          idx_clear;
  logic          idx_inc;
  logic          mem_rd;
  logic          op_clear;

  assign b          = char_in.char_byte;
  assign accept     = char_in.valid && char_in.ready;
  assign op_info    = tlex_pkg::op_lookup(b);
  assign op_hit     = op_info[5];
  assign blank      = (b == tlex_pkg::CH_SPACE) || (b == tlex_pkg::CH_NL) ||
                      (b == tlex_pkg::CH_TAB) || (b == tlex_pkg::CH_NUL);
  assign is_word    = !op_hit && !blank;
  assign store_ok   = length < LW'(MAX_WORD);
  assign need_flush = ((op_hit || blank) && (length != '0)) ||
                      (is_word && char_in.end_of_text);
  assign first      = (length == '0);
  assign out_free   = !out_valid || tok_out.ready;
  assign last_byte  = (LW'(idx) + LW'(1)) == length;

  always_comb begin
    for (int k = 0; k < tlex_pkg::NUM_KW; k++) begin
      kw_match_next[k] = (first || kw_match[k]) &&
                         tlex_pkg::kw_byte_ok(4'(k), 6'(length), b);
    end
  end

  // Word classification from the trackers.
  always_comb begin
    word_kind = tlex_pkg::KIND_IDENT;
    if (quote_first) begin
      word_kind = tlex_pkg::KIND_CHARC;
    end else if (!nondig_seen) begin
      word_kind = tlex_pkg::KIND_INT;
    end else if (nondig_dot) begin
      word_kind = tlex_pkg::KIND_FLOAT;
    end
    if (!overflow) begin
      for (int k = tlex_pkg::NUM_KW - 1; k >= 0; k--) begin
        if (kw_match[k] && (6'(length) == tlex_pkg::kw_len(4'(k)))) begin
          word_kind = tlex_pkg::KIND_KW0 + tlex_pkg::KIND_W'(k);
        end
      end
    end
  end

  assign word_multi = (word_kind == tlex_pkg::KIND_IDENT) ||
                      (word_kind == tlex_pkg::KIND_INT) ||
                      (word_kind == tlex_pkg::KIND_FLOAT);

  always_comb begin
    state_next = state;
    unique case (state)
      tlex_pkg::ST_IDLE: begin
        if (accept) begin
          if (need_flush) begin
            state_next = tlex_pkg::ST_FLUSH;
          end else if (op_hit) begin
            state_next = tlex_pkg::ST_OP;
          end
        end
      end
      tlex_pkg::ST_FLUSH: begin
        state_next = word_multi ? tlex_pkg::ST_READ : tlex_pkg::ST_ONE;
      end
      tlex_pkg::ST_ONE: begin
        if (out_free) begin
          state_next = op_pend ? tlex_pkg::ST_OP : tlex_pkg::ST_IDLE;
        end
      end
      tlex_pkg::ST_READ: begin
        state_next = tlex_pkg::ST_WORD;
      end
      tlex_pkg::ST_WORD: begin
        if (out_free) begin
          if (!last_byte) begin
            state_next = tlex_pkg::ST_READ;
          end else begin
            state_next = op_pend ? tlex_pkg::ST_OP : tlex_pkg::ST_IDLE;
          end
        end
      end
      tlex_pkg::ST_OP: begin
        if (out_free) begin
          state_next = tlex_pkg::ST_IDLE;
        end
      end
      default: state_next = tlex_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ld_out     = 1'b0;
    ld_kind    = word_kind;
    ld_value   = '0;
    ld_end     = 1'b1;
    ld_trunc   = overflow;
    ld_last    = !op_pend;
    word_clear = 1'b0;
    idx_clear  = 1'b0;
    idx_inc    = 1'b0;
    mem_rd     = 1'b0;
    op_clear   = 1'b0;
    unique case (state)
      tlex_pkg::ST_IDLE:  ;
      tlex_pkg::ST_FLUSH: idx_clear = 1'b1;
      tlex_pkg::ST_ONE: begin
        ld_out     = out_free;
        word_clear = out_free;
        if (word_kind == tlex_pkg::KIND_CHARC && length >= LW'(2)) begin
          ld_value = char_val;
        end
      end
      tlex_pkg::ST_READ: mem_rd = 1'b1;
      tlex_pkg::ST_WORD: begin
        ld_out     = out_free;
        ld_value   = rd_data;
        ld_end     = last_byte;
        ld_last    = last_byte && !op_pend;
        word_clear = out_free && last_byte;
        idx_inc    = out_free && !last_byte;
      end
      tlex_pkg::ST_OP: begin
        ld_out   = out_free;
        ld_kind  = op_kind;
        ld_trunc = 1'b0;
        ld_last  = 1'b1;
        op_clear = out_free;
      end
      default: ;
    endcase
  end

  assign char_in.ready = (state == tlex_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (accept && is_word && store_ok) begin
      word_store[length[AW-1:0]] <= b;
    end
    if (mem_rd) begin
      rd_data <= word_store[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tlex_pkg::ST_IDLE;
      length    <= '0;
      overflow  <= 1'b0;
      op_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        op_pend <= op_hit;
        if (is_word) begin
          if (store_ok) begin
            length <= length + LW'(1);
          end else begin
            overflow <= 1'b1;
          end
        end
      end
      if (word_clear) begin
        length   <= '0;
        overflow <= 1'b0;
      end
      if (op_clear) begin
        op_pend <= 1'b0;
      end
      if (ld_out) begin
        out_valid <= 1'b1;
      end else if (tok_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= tlex_pkg::KIND_OP0 + {1'b0, op_info[4:0]};
    end
    if (accept && is_word && store_ok) begin
      kw_match <= kw_match_next;
      if (first) begin
        quote_first <= (b == tlex_pkg::CH_QUOTE);
        nondig_seen <= !tlex_pkg::is_digit(b);
        nondig_dot  <= (b == tlex_pkg::CH_DOT);
      end else if (!nondig_seen && !tlex_pkg::is_digit(b)) begin
        nondig_seen <= 1'b1;
        nondig_dot  <= (b == tlex_pkg::CH_DOT);
      end
      if (length == LW'(1)) begin
        char_val <= b;
      end
    end
    if (idx_clear) begin
      idx <= '0;
    end else if (idx_inc) begin
      idx <= idx + AW'(1);
    end
    if (ld_out) begin
      out_kind  <= ld_kind;
      out_value <= ld_value;
      out_end   <= ld_end;
      out_trunc <= ld_trunc;
      out_last  <= ld_last;
    end
  end

  assign tok_out.valid      = out_valid;
  assign tok_out.kind       = out_kind;
  assign tok_out.value_byte = out_value;
  assign tok_out.token_end  = out_end;
  assign tok_out.truncated  = out_trunc;
  assign tok_out.run_last   = out_last;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LW'(MAX_WORD))
    else $error("word length beyond store depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflow |-> (length == LW'(MAX_WORD)))
    else $error("overflow set while store not full");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == tlex_pkg::ST_WORD) |-> (LW'(idx) < length))
    else $error("word read beyond stored length");

  a_op_busy: assert property (@(posedge clk) disable iff (rst)
    op_pend |-> (state != tlex_pkg::ST_IDLE))
    else $error("operator pending while idle");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (ld_out && ld_last) |=> (state == tlex_pkg::ST_IDLE))
    else $error("sequencer busy after final result");
`endif

endmodule
